// ===== rtl/ik_pkg.sv =====
`timescale 1ns / 1ps
package ik_pkg;

  // CORDIC depth, shared by the rotation and vectoring units
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN = 24;

  // field widths
  localparam int LEN_W = 16;
  localparam int OFS_W = 16;
  localparam int ANG_W = 17;
  localparam int TGT_W = 16;
  localparam int SH_W = 17;
  localparam int EL_W = 16;
  localparam int ST_W = 2;
  localparam int CFG_W = 17;
  localparam int CFG_IDX_W = 3;

  // internal widths
  localparam int AR_W = 19;            // angle during range reduction
  localparam int ROT_W = 34;           // rotation CORDIC x/y, Q2.30
  localparam int Z_W = 26;             // angle accumulator, 2^-16 degree
  localparam int VEC_W = 42;           // vectoring CORDIC x/y
  localparam int P_W = ROT_W + TGT_W;  // frame products
  localparam int S_W = P_W + 1;
  localparam int PX_W = 19;            // mapped point, Q8.8
  localparam int PP_W = 2 * PX_W;
  localparam int L2S_W = 51;           // squared distance, scaled by 2^16
  localparam int L_W = 26;             // distance, Q8.16
  localparam int ISQ_W = 62;
  localparam int ISQ_STEPS = ISQ_W / 2;
  localparam int ISQ_RW = ISQ_STEPS;
  localparam int N_W = 53;             // acos numerators, signed
  localparam int D_W = 52;             // acos denominators and magnitudes
  localparam int DIV_W = 53;
  localparam int Q_W = 31;             // acos argument magnitude, Q1.30
  localparam int DIV_STEPS = Q_W;
  localparam int U_W = 32;
  localparam int SUM_W = 28;
  localparam int RND_W = SUM_W - 9;

  // unit latencies
  localparam int ROT_LAT = CORDIC_STEPS + 2;
  localparam int VEC_LAT = CORDIC_STEPS + 1;

  // constants
  localparam int ROT_GAIN = 652032874;
  localparam int ANG_90 = 11520;
  localparam int ANG_180 = 23040;
  localparam int ANG_360 = 46080;
  localparam int DEG90_Z = 90 * 65536;
  localparam int DEG180_Z = 180 * 65536;
  localparam int HALF_Q30 = 1 << 29;
  localparam int HALF_Q97 = 256;
  localparam int SH_LO = -23040;
  localparam int SH_HI = 46080;
  localparam int EL_LO = 23040;
  localparam int EL_HI = 46080;
  localparam int SH_MIN = 12800;
  localparam int SH_MAX = 23040;
  localparam int EL_MIN = 28160;
  localparam int EL_MAX = 38400;
  localparam logic [ISQ_W-1:0] ONE_Q60 = ISQ_W'(1) << 60;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFS_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFS_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_LIMIT = 2'd1;
  localparam logic [ST_W-1:0] ST_UNREACH = 2'd2;

  typedef logic signed [ROT_W-1:0] rot_t;
  typedef logic signed [Z_W-1:0] zang_t;
  typedef logic signed [VEC_W-1:0] vec_t;

  // atan(2^-i) in 2^-16 degree
  function automatic zang_t atan_step(input int i);
    case (i)
      0: return Z_W'(2949120);
      1: return Z_W'(1740967);
      2: return Z_W'(919879);
      3: return Z_W'(466945);
      4: return Z_W'(234379);
      5: return Z_W'(117304);
      6: return Z_W'(58666);
      7: return Z_W'(29335);
      8: return Z_W'(14668);
      9: return Z_W'(7334);
      10: return Z_W'(3667);
      11: return Z_W'(1833);
      12: return Z_W'(917);
      13: return Z_W'(458);
      14: return Z_W'(229);
      15: return Z_W'(115);
      16: return Z_W'(57);
      17: return Z_W'(29);
      18: return Z_W'(14);
      19: return Z_W'(7);
      20: return Z_W'(4);
      21: return Z_W'(2);
      22: return Z_W'(1);
      default: return '0;
    endcase
  endfunction

endpackage

// ===== rtl/ik_if.sv =====
`timescale 1ns / 1ps
interface ik_in_if import ik_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [TGT_W-1:0] target_x;
  logic signed [TGT_W-1:0] target_y;

  modport source (output valid, output target_x, output target_y, input ready);
  modport sink (input valid, input target_x, input target_y, output ready);
endinterface

interface ik_out_if import ik_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [SH_W-1:0] shoulder_angle;
  logic [EL_W-1:0] elbow_angle;
  logic [ST_W-1:0] move_status;

  modport source (output valid, output shoulder_angle, output elbow_angle,
                  output move_status, input ready);
  modport sink (input valid, input shoulder_angle, input elbow_angle,
                input move_status, output ready);
endinterface

// ===== rtl/ik_cordic_rot.sv =====
`timescale 1ns / 1ps
module ik_cordic_rot import ik_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ANG_W-1:0] ang,
  output rot_t                    cos_q,
  output rot_t                    sin_q
);

  rot_t  x_r [CORDIC_STEPS+1];
  rot_t  y_r [CORDIC_STEPS+1];
  zang_t z_r [CORDIC_STEPS+1];
  logic  neg_r [CORDIC_STEPS+1];
  rot_t  c_r, s_r;

  // range reduction to [-90,90]
  always_ff @(posedge clk) begin
    logic signed [AR_W-1:0] a;
    logic n;
    if (en) begin
      a = AR_W'(ang);
      for (int k = 0; k < 2; k++) begin
        if (a > ANG_180) a = AR_W'(a - ANG_360);
        if (a <= -ANG_180) a = AR_W'(a + ANG_360);
      end
      n = 1'b0;
      if (a > ANG_90) begin
        a = AR_W'(a - ANG_180);
        n = 1'b1;
      end else if (a < -ANG_90) begin
        a = AR_W'(a + ANG_180);
        n = 1'b1;
      end
      x_r[0] <= ROT_W'(ROT_GAIN);
      y_r[0] <= '0;
      z_r[0] <= Z_W'(a) <<< 9;
      neg_r[0] <= n;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam zang_t ATAN_I = atan_step(i);
    rot_t xn, yn;
    zang_t zn;
    always_comb begin
      if (z_r[i] >= 0) begin
        xn = x_r[i] - (y_r[i] >>> i);
        yn = y_r[i] + (x_r[i] >>> i);
        zn = z_r[i] - ATAN_I;
      end else begin
        xn = x_r[i] + (y_r[i] >>> i);
        yn = y_r[i] - (x_r[i] >>> i);
        zn = z_r[i] + ATAN_I;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= xn;
        y_r[i+1] <= yn;
        z_r[i+1] <= zn;
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= neg_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
      s_r <= neg_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
    end
  end

  assign cos_q = c_r;
  assign sin_q = s_r;

endmodule

// ===== rtl/ik_cordic_vec.sv =====
`timescale 1ns / 1ps
module ik_cordic_vec import ik_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  vec_t  x_in,
  input  vec_t  y_in,
  output zang_t ang
);

  vec_t  x_r [CORDIC_STEPS+1];
  vec_t  y_r [CORDIC_STEPS+1];
  zang_t z_r [CORDIC_STEPS+1];

  // quarter-turn pre-rotation for the left half plane
  always_ff @(posedge clk) begin
    if (en) begin
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x_r[0] <= y_in;
          y_r[0] <= -x_in;
          z_r[0] <= Z_W'(DEG90_Z);
        end else begin
          x_r[0] <= -y_in;
          y_r[0] <= x_in;
          z_r[0] <= -Z_W'(DEG90_Z);
        end
      end else begin
        x_r[0] <= x_in;
        y_r[0] <= y_in;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam zang_t ATAN_I = atan_step(i);
    vec_t xn, yn;
    zang_t zn;
    always_comb begin
      if (y_r[i] > 0) begin
        xn = x_r[i] + (y_r[i] >>> i);
        yn = y_r[i] - (x_r[i] >>> i);
        zn = z_r[i] + ATAN_I;
      end else begin
        xn = x_r[i] - (y_r[i] >>> i);
        yn = y_r[i] + (x_r[i] >>> i);
        zn = z_r[i] - ATAN_I;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= xn;
        y_r[i+1] <= yn;
        z_r[i+1] <= zn;
      end
    end
  end

  assign ang = z_r[CORDIC_STEPS];

endmodule

// ===== rtl/ik_isqrt.sv =====
`timescale 1ns / 1ps
module ik_isqrt import ik_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [ISQ_W-1:0]  rad,
  output logic [ISQ_RW-1:0] root
);

  logic [ISQ_W-1:0] n_r [ISQ_STEPS];
  logic [ISQ_W-1:0] res_r [ISQ_STEPS];

  // one result bit per stage, most significant first
  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
    localparam logic [ISQ_W-1:0] BITV = ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - k));
    logic [ISQ_W-1:0] n_in, res_in, trial, n_nxt, res_nxt;
    if (k == 0) begin : g_first
      assign n_in = rad;
      assign res_in = '0;
    end else begin : g_next
      assign n_in = n_r[k-1];
      assign res_in = res_r[k-1];
    end
    always_comb begin
      trial = res_in + BITV;
      if (n_in >= trial) begin
        n_nxt = n_in - trial;
        res_nxt = (res_in >> 1) + BITV;
      end else begin
        n_nxt = n_in;
        res_nxt = res_in >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k] <= n_nxt;
        res_r[k] <= res_nxt;
      end
    end
  end

  assign root = res_r[ISQ_STEPS-1][ISQ_RW-1:0];

endmodule

// ===== rtl/ik_div.sv =====
`timescale 1ns / 1ps
module ik_div import ik_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [D_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic [Q_W-1:0] quo
);

  // restoring division, num <= den, one quotient bit per stage
  logic [DIV_W-1:0] r_r [DIV_STEPS];
  logic [DIV_W-1:0] d_r [DIV_STEPS];
  logic [Q_W-1:0]   q_r [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [DIV_W-1:0] r_sh, d_in;
    logic [Q_W-1:0] q_sh;
    if (k == 0) begin : g_first
      assign r_sh = DIV_W'(num);
      assign d_in = DIV_W'(den);
      assign q_sh = '0;
    end else begin : g_next
      assign r_sh = r_r[k-1] << 1;
      assign d_in = d_r[k-1];
      assign q_sh = q_r[k-1] << 1;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[k] <= d_in;
        if (r_sh >= d_in) begin
          r_r[k] <= r_sh - d_in;
          q_r[k] <= q_sh | Q_W'(1);
        end else begin
          r_r[k] <= r_sh;
          q_r[k] <= q_sh;
        end
      end
    end
  end

  assign quo = q_r[DIV_STEPS-1];

endmodule

// ===== rtl/two_link_inverse_kinematics.sv =====
`timescale 1ns / 1ps
// Two-link planar arm inverse kinematics, fully pipelined.
// in_tgt (sink): target point (target_x, target_y), signed Q8.8 in the task
//   frame. A word moves when valid and ready are both high.
// out_res (source): shoulder_angle (signed Q9.7 deg), elbow_angle (Q9.7 deg)
//   and move_status (ok / outside joint limits / unreachable), one word per
//   input word, in order.
// cfg_*: write port for link lengths and task frame (index 0..4); writes to
//   other indexes are dropped. Write only while the pipeline is empty.
// Structure: the chain is frame CORDIC, distance sqrt, the two acos dividers,
//   the two acos sqrts and the angle CORDICs, each one bit or one
//   micro-rotation per stage.
// Throughput: one word per cycle while out_res is not stalled.
// Stall: a single enable moves every stage; when out_res holds a word that is
//   not taken, the whole pipeline freezes and in_tgt.ready drops.
// Reset: rst_n (sync, active low) empties the pipeline and clears all
//   configuration to zero (identity frame, zero link lengths).
module two_link_inverse_kinematics import ik_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  ik_in_if.sink                in_tgt,
  ik_out_if.source             out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // alignment of side data against the units
  localparam int XY_DLY = ROT_LAT;
  localparam int L2_DLY = ISQ_STEPS;
  localparam int SG_DLY = DIV_STEPS;
  localparam int U_DLY = ISQ_STEPS + 1;
  localparam int PX_DLY = 2 * ISQ_STEPS + DIV_STEPS + 6;
  localparam int UR_DLY = ISQ_STEPS + DIV_STEPS + VEC_LAT + 2;
  localparam int VLD_LEN = ROT_LAT + 2 * ISQ_STEPS + DIV_STEPS + VEC_LAT + 9;

  logic en;

  // ---------------- configuration ----------------
  logic [LEN_W-1:0]         upper_r, fore_r;
  logic signed [OFS_W-1:0]  ofs_x_r, ofs_y_r;
  logic signed [ANG_W-1:0]  angle_r;
  logic [2*LEN_W-1:0]       aa_r, bb_r, ab_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= '0;
      fore_r <= '0;
      ofs_x_r <= '0;
      ofs_y_r <= '0;
      angle_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UPPER: upper_r <= cfg_wdata[LEN_W-1:0];
        REG_FORE:  fore_r <= cfg_wdata[LEN_W-1:0];
        REG_OFS_X: ofs_x_r <= cfg_wdata[OFS_W-1:0];
        REG_OFS_Y: ofs_y_r <= cfg_wdata[OFS_W-1:0];
        REG_ANGLE: angle_r <= cfg_wdata[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  // link-length products, static while words are in flight if cfg is written only while empty
  always_ff @(posedge clk) begin
    aa_r <= upper_r * upper_r;
    bb_r <= fore_r * fore_r;
    ab_r <= upper_r * fore_r;
  end

  // ---------------- handshake and valid pipe ----------------
  logic [VLD_LEN-1:0] v_r;
  logic               out_valid_r;

  assign en = !out_valid_r || out_res.ready;
  assign in_tgt.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r <= {v_r[VLD_LEN-2:0], in_tgt.valid};
      out_valid_r <= v_r[VLD_LEN-1];
    end
  end

  // ---------------- frame rotation ----------------
  rot_t cos_q, sin_q;
  logic signed [TGT_W-1:0] tx_d_r [XY_DLY];
  logic signed [TGT_W-1:0] ty_d_r [XY_DLY];

  ik_cordic_rot u_rot (
    .clk   (clk),
    .en    (en),
    .ang   (angle_r),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      tx_d_r[0] <= in_tgt.target_x;
      ty_d_r[0] <= in_tgt.target_y;
      for (int k = 1; k < XY_DLY; k++) begin
        tx_d_r[k] <= tx_d_r[k-1];
        ty_d_r[k] <= ty_d_r[k-1];
      end
    end
  end

  // B1: products
  logic signed [P_W-1:0] cx_r, sy_r, sx_r, cy_r;
  always_ff @(posedge clk) begin
    if (en) begin
      cx_r <= cos_q * tx_d_r[XY_DLY-1];
      sy_r <= sin_q * ty_d_r[XY_DLY-1];
      sx_r <= sin_q * tx_d_r[XY_DLY-1];
      cy_r <= cos_q * ty_d_r[XY_DLY-1];
    end
  end

  // B2: round Q2.30 back to Q8.8 and translate
  logic signed [S_W-1:0]  sum_x, sum_y;
  logic signed [PX_W-1:0] px_r, py_r;
  always_comb begin
    sum_x = S_W'(cx_r) + S_W'(sy_r) + S_W'(HALF_Q30);
    sum_y = S_W'(cy_r) - S_W'(sx_r) + S_W'(HALF_Q30);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= PX_W'((sum_x >>> 30) + S_W'(ofs_x_r));
      py_r <= PX_W'((sum_y >>> 30) + S_W'(ofs_y_r));
    end
  end

  // B3: squares
  logic signed [PP_W-1:0] pxx_r, pyy_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pxx_r <= px_r * px_r;
      pyy_r <= py_r * py_r;
    end
  end

  // B4: squared distance scaled by 2^16
  logic [L2S_W-1:0] l2s_r;
  always_ff @(posedge clk) begin
    if (en) l2s_r <= (L2S_W'(pxx_r) + L2S_W'(pyy_r)) << 16;
  end

  // ---------------- distance ----------------
  logic [ISQ_RW-1:0] sq1_root;
  logic [L2S_W-1:0]  l2s_d_r [L2_DLY];

  ik_isqrt u_sqrt_dist (
    .clk  (clk),
    .en   (en),
    .rad  (ISQ_W'(l2s_r)),
    .root (sq1_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      l2s_d_r[0] <= l2s_r;
      for (int k = 1; k < L2_DLY; k++) l2s_d_r[k] <= l2s_d_r[k-1];
    end
  end

  // C1: law-of-cosines numerators and denominators
  logic [L_W-1:0]        dist_l;
  logic [L2S_W-1:0]      l2s_al;
  logic signed [N_W-1:0] n1_r, n2_r;
  logic [D_W-1:0]        d1_r, d2_r;
  logic                  fz_r;

  assign dist_l = sq1_root[L_W-1:0];
  assign l2s_al = l2s_d_r[L2_DLY-1];

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r <= ((N_W'(aa_r) - N_W'(bb_r)) << 16) + N_W'(l2s_al);
      n2_r <= ((N_W'(aa_r) + N_W'(bb_r)) << 16) - N_W'(l2s_al);
      d1_r <= (D_W'(upper_r) * D_W'(dist_l)) << 9;
      d2_r <= D_W'(ab_r) << 17;
      fz_r <= (dist_l == '0) || (upper_r == '0) || (fore_r == '0);
    end
  end

  // C2: magnitudes and range check
  logic [D_W-1:0] mag1_r, mag2_r, dd1_r, dd2_r;
  logic [1:0]     sgn_r;
  logic           ur_r;
  logic [D_W-1:0] mag1, mag2;

  always_comb begin
    mag1 = n1_r[N_W-1] ? D_W'(-n1_r) : D_W'(n1_r);
    mag2 = n2_r[N_W-1] ? D_W'(-n2_r) : D_W'(n2_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r <= mag1;
      mag2_r <= mag2;
      dd1_r <= d1_r;
      dd2_r <= d2_r;
      sgn_r <= {n2_r[N_W-1], n1_r[N_W-1]};
      ur_r <= fz_r || (mag1 > d1_r) || (mag2 > d2_r);
    end
  end

  // ---------------- acos arguments ----------------
  logic [Q_W-1:0] q1, q2;
  logic [1:0]     sgn_d_r [SG_DLY];
  logic           ur_d_r [UR_DLY];

  ik_div u_div_sh (
    .clk (clk),
    .en  (en),
    .num (mag1_r),
    .den (dd1_r),
    .quo (q1)
  );

  ik_div u_div_el (
    .clk (clk),
    .en  (en),
    .num (mag2_r),
    .den (dd2_r),
    .quo (q2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sgn_d_r[0] <= sgn_r;
      for (int k = 1; k < SG_DLY; k++) sgn_d_r[k] <= sgn_d_r[k-1];
      ur_d_r[0] <= ur_r;
      for (int k = 1; k < UR_DLY; k++) ur_d_r[k] <= ur_d_r[k-1];
    end
  end

  // E1: signed argument and its square
  logic signed [U_W-1:0] u1_r, u2_r;
  logic [ISQ_W-1:0]      qq1_r, qq2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      u1_r <= sgn_d_r[SG_DLY-1][0] ? -U_W'(q1) : U_W'(q1);
      u2_r <= sgn_d_r[SG_DLY-1][1] ? -U_W'(q2) : U_W'(q2);
      qq1_r <= ISQ_W'(q1) * ISQ_W'(q1);
      qq2_r <= ISQ_W'(q2) * ISQ_W'(q2);
    end
  end

  // E2: 1 - u^2 in Q2.60
  logic [ISQ_W-1:0] rad1_r, rad2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      rad1_r <= ONE_Q60 - qq1_r;
      rad2_r <= ONE_Q60 - qq2_r;
    end
  end

  logic [ISQ_RW-1:0]     sq_sh, sq_el;
  logic signed [U_W-1:0] u1_d_r [U_DLY];
  logic signed [U_W-1:0] u2_d_r [U_DLY];

  ik_isqrt u_sqrt_sh (
    .clk  (clk),
    .en   (en),
    .rad  (rad1_r),
    .root (sq_sh)
  );

  ik_isqrt u_sqrt_el (
    .clk  (clk),
    .en   (en),
    .rad  (rad2_r),
    .root (sq_el)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      u1_d_r[0] <= u1_r;
      u2_d_r[0] <= u2_r;
      for (int k = 1; k < U_DLY; k++) begin
        u1_d_r[k] <= u1_d_r[k-1];
        u2_d_r[k] <= u2_d_r[k-1];
      end
    end
  end

  // point held until the angle CORDICs
  logic signed [PX_W-1:0] px_d_r [PX_DLY];
  logic signed [PX_W-1:0] py_d_r [PX_DLY];
  always_ff @(posedge clk) begin
    if (en) begin
      px_d_r[0] <= px_r;
      py_d_r[0] <= py_r;
      for (int k = 1; k < PX_DLY; k++) begin
        px_d_r[k] <= px_d_r[k-1];
        py_d_r[k] <= py_d_r[k-1];
      end
    end
  end

  // ---------------- angles ----------------
  zang_t z_pt, z_ac1, z_ac2;

  ik_cordic_vec u_vec_pt (
    .clk  (clk),
    .en   (en),
    .x_in (VEC_W'(px_d_r[PX_DLY-1]) <<< 20),
    .y_in (VEC_W'(py_d_r[PX_DLY-1]) <<< 20),
    .ang  (z_pt)
  );

  ik_cordic_vec u_vec_ac1 (
    .clk  (clk),
    .en   (en),
    .x_in (VEC_W'(u1_d_r[U_DLY-1])),
    .y_in (VEC_W'(sq_sh)),
    .ang  (z_ac1)
  );

  ik_cordic_vec u_vec_ac2 (
    .clk  (clk),
    .en   (en),
    .x_in (VEC_W'(u2_d_r[U_DLY-1])),
    .y_in (VEC_W'(sq_el)),
    .ang  (z_ac2)
  );

  // F1: round half up to Q9.7 and clamp
  logic signed [SUM_W-1:0] sh_sum, el_sum;
  logic signed [RND_W-1:0] sh_rnd, el_rnd;
  logic signed [SH_W-1:0]  sh_r;
  logic [EL_W-1:0]         el_r;
  logic                    ur_f_r;

  always_comb begin
    sh_sum = SUM_W'(z_pt) + SUM_W'(z_ac1) + SUM_W'(HALF_Q97);
    el_sum = SUM_W'(z_ac2) + SUM_W'(DEG180_Z) + SUM_W'(HALF_Q97);
    sh_rnd = RND_W'(sh_sum >>> 9);
    el_rnd = RND_W'(el_sum >>> 9);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sh_rnd < SH_LO) sh_r <= SH_W'(SH_LO);
      else if (sh_rnd > SH_HI) sh_r <= SH_W'(SH_HI);
      else sh_r <= SH_W'(sh_rnd);
      if (el_rnd < EL_LO) el_r <= EL_W'(EL_LO);
      else if (el_rnd > EL_HI) el_r <= EL_W'(EL_HI);
      else el_r <= EL_W'(el_rnd);
      ur_f_r <= ur_d_r[UR_DLY-1];
    end
  end

  // F2: joint-limit check into the output register
  logic signed [SH_W-1:0] out_sh_r;
  logic [EL_W-1:0]        out_el_r;
  logic [ST_W-1:0]        out_st_r;
  logic                   lim;

  assign lim = (sh_r > SH_MAX) || (sh_r < SH_MIN) || (el_r < EL_MIN) || (el_r > EL_MAX);

  always_ff @(posedge clk) begin
    if (en) begin
      if (ur_f_r) begin
        out_sh_r <= '0;
        out_el_r <= '0;
        out_st_r <= ST_UNREACH;
      end else begin
        out_sh_r <= sh_r;
        out_el_r <= el_r;
        out_st_r <= lim ? ST_LIMIT : ST_OK;
      end
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.shoulder_angle = out_sh_r;
  assign out_res.elbow_angle = out_el_r;
  assign out_res.move_status = out_st_r;

`ifndef SYNTH
  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == ST_UNREACH) |-> (out_sh_r == '0 && out_el_r == '0))
    else $error("unreachable word with nonzero angles");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_st_r == ST_OK || out_st_r == ST_LIMIT || out_st_r == ST_UNREACH))
    else $error("bad status code");

  a_elbow_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r != ST_UNREACH) |-> (out_el_r >= EL_LO && out_el_r <= EL_HI))
    else $error("elbow angle outside clamp range");

  a_ok_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == ST_OK) |->
      (out_sh_r >= SH_MIN && out_sh_r <= SH_MAX && out_el_r >= EL_MIN && out_el_r <= EL_MAX))
    else $error("ok status outside joint limits");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipeline moved during stall");
`endif

endmodule
